/* design/qte_pkg.sv */
// qte_pkg: widths, angle constants, codes and lookup functions shared by the
// quaternion-to-Euler pipeline. No dependencies.
`default_nettype none

package qte_pkg;

  localparam int IW        = 24;             // internal component width, Q2.22
  localparam int PF        = 2 * (IW - 2);   // fraction bits of products
  localparam int PW        = 2 * IW;         // product width
  localparam int UW        = PW + 3;         // sum of four squares
  localparam int TW        = PW + 1;         // x*w - y*z
  localparam int AW        = PW + 4;         // atan2 argument width
  localparam int CW        = 32;             // CORDIC x/y width
  localparam int ZW        = 20;             // angle width, Q16
  localparam int SW        = 32;             // asin argument, Q30
  localparam int S_DN      = PF - 30;
  localparam int SQ_STEPS  = 31;             // result bits of the square root
  localparam int RW        = 2 * SQ_STEPS;   // square root radicand width
  localparam int NORM_HALF = 5;
  localparam int NORM_STEPS = 2 * NORM_HALF;
  localparam int OW        = 16;

  localparam logic signed [ZW-1:0] Z_HALF_PI = ZW'(102944);
  localparam logic signed [ZW-1:0] Z_PI      = ZW'(205887);
  localparam logic signed [ZW-1:0] Z_TWO_PI  = ZW'(411774);
  localparam logic signed [OW-1:0] OUT_HALF_PI = OW'(6434);

  localparam logic [1:0] POLE_NONE  = 2'd0;
  localparam logic [1:0] POLE_NORTH = 2'd1;
  localparam logic [1:0] POLE_SOUTH = 2'd2;

  typedef struct packed {
    logic [1:0]            pole;
    logic signed [SW-1:0]  s;
    logic signed [AW-1:0]  yaw_y;
    logic signed [AW-1:0]  yaw_x;
    logic signed [AW-1:0]  roll_y;
    logic signed [AW-1:0]  roll_x;
  } qte_side_t;

  typedef struct packed {
    logic [RW-1:0] n;
    logic [RW-1:0] r;
    qte_side_t     side;
  } qte_sqrt_t;

  function automatic logic signed [ZW-1:0] atan_q16(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0:       v = ZW'(51472);
      1:       v = ZW'(30386);
      2:       v = ZW'(16055);
      3:       v = ZW'(8150);
      4:       v = ZW'(4091);
      5:       v = ZW'(2047);
      6:       v = ZW'(1024);
      7:       v = ZW'(512);
      8:       v = ZW'(256);
      9:       v = ZW'(128);
      10:      v = ZW'(64);
      11:      v = ZW'(32);
      12:      v = ZW'(16);
      13:      v = ZW'(8);
      14:      v = ZW'(4);
      15:      v = ZW'(2);
      16:      v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // binary search shift amounts: right steps first, then left steps
  function automatic int norm_shift(input int j);
    int k;
    k = 16 >> (j % NORM_HALF);
    return k;
  endfunction

endpackage

`default_nettype wire

/* design/quaternion_to_euler.sv */
// quaternion_to_euler: fully pipelined quaternion to pitch/yaw/roll converter.
// Stages: 6 arithmetic stages, 31 square-root stages, 11 + CORDIC_STEPS
// atan2 stages, one output stage.
// Throughput one item per clock; the whole pipe halts only while a finished
// item sits in the output register and the far side stalls it.
// Reset clears valid bits only; no clearing pass. Depends on qte_pkg, qte_atan2.
`default_nettype none

module quaternion_to_euler
  import qte_pkg::*;
#(
  parameter int QUAT_WIDTH   = 16,
  parameter int CORDIC_STEPS = 14
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [QUAT_WIDTH-1:0] quat_x_i,
  input  logic signed [QUAT_WIDTH-1:0] quat_y_i,
  input  logic signed [QUAT_WIDTH-1:0] quat_z_i,
  input  logic signed [QUAT_WIDTH-1:0] quat_w_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [OW-1:0]         pitch_angle_o,
  output logic signed [OW-1:0]         yaw_angle_o,
  output logic signed [OW-1:0]         roll_angle_o,
  output logic [1:0]                   pole_case_o
);

  localparam int LA = 1 + NORM_STEPS + CORDIC_STEPS;
  localparam int NV = 6 + SQ_STEPS + LA + 1;

  logic en;
  logic [NV-1:0] vld_q;

  assign en          = !(vld_q[NV-1] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[NV-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NV-2:0], in_valid_i};
    end
  end

  // stage 1: align to Q2.22
  logic signed [QUAT_WIDTH-1:0] q_in [4];
  logic signed [IW-1:0]         a_d [4];
  logic signed [IW-1:0]         a_q [4];

  assign q_in[0] = quat_x_i;
  assign q_in[1] = quat_y_i;
  assign q_in[2] = quat_z_i;
  assign q_in[3] = quat_w_i;

  for (genvar c = 0; c < 4; c++) begin : g_align
    if (QUAT_WIDTH >= IW) begin : g_drop
      assign a_d[c] = q_in[c][QUAT_WIDTH-1 -: IW];
    end else begin : g_pad
      assign a_d[c] = {q_in[c], {(IW-QUAT_WIDTH){1'b0}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q <= a_d;
    end
  end

  // stage 2: products
  logic signed [PW-1:0] p_xx_q, p_yy_q, p_zz_q, p_ww_q, p_xw_q;
  logic signed [PW-1:0] p_yz_q, p_wy_q, p_zx_q, p_wz_q, p_xy_q;
  logic signed [IW-1:0] x2_q, y2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_xx_q <= a_q[0] * a_q[0];
      p_yy_q <= a_q[1] * a_q[1];
      p_zz_q <= a_q[2] * a_q[2];
      p_ww_q <= a_q[3] * a_q[3];
      p_xw_q <= a_q[0] * a_q[3];
      p_yz_q <= a_q[1] * a_q[2];
      p_wy_q <= a_q[3] * a_q[1];
      p_zx_q <= a_q[2] * a_q[0];
      p_wz_q <= a_q[3] * a_q[2];
      p_xy_q <= a_q[0] * a_q[1];
      x2_q   <= a_q[0];
      y2_q   <= a_q[1];
    end
  end

  // stage 3: sums
  localparam logic signed [AW-1:0] ONE_A = AW'(64'sd1 <<< PF);

  logic signed [UW-1:0] unit_q;
  logic signed [TW-1:0] test_q;
  logic signed [AW-1:0] yn_q, yd_q, rn_q, rd_q;
  logic signed [IW-1:0] x3_q, y3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      unit_q <= UW'(p_xx_q) + UW'(p_yy_q) + UW'(p_zz_q) + UW'(p_ww_q);
      test_q <= TW'(p_xw_q) - TW'(p_yz_q);
      yn_q   <= (AW'(p_wy_q) + AW'(p_zx_q)) <<< 1;
      yd_q   <= ONE_A - ((AW'(p_xx_q) + AW'(p_yy_q)) <<< 1);
      rn_q   <= (AW'(p_wz_q) + AW'(p_xy_q)) <<< 1;
      rd_q   <= ONE_A - ((AW'(p_zz_q) + AW'(p_xx_q)) <<< 1);
      x3_q   <= x2_q;
      y3_q   <= y2_q;
    end
  end

  // stage 4: pole test, asin argument, argument selection
  localparam logic signed [63:0] ONE_64 = 64'sd1 <<< PF;

  logic signed [63:0] t64, u64, lhs, rhs, s2;
  qte_side_t side4_d, side4_q;

  always_comb begin
    t64 = 64'(test_q);
    u64 = 64'(unit_q);
    lhs = t64 * 64'sd2000;
    rhs = u64 * 64'sd999;
    s2  = t64 <<< 1;
    if (s2 > ONE_64) begin
      s2 = ONE_64;
    end else if (s2 < -ONE_64) begin
      s2 = -ONE_64;
    end
    side4_d.s      = SW'(s2 >>> S_DN);
    side4_d.roll_y = rn_q;
    side4_d.roll_x = rd_q;
    side4_d.yaw_y  = yn_q;
    side4_d.yaw_x  = yd_q;
    side4_d.pole   = POLE_NONE;
    if (lhs > rhs) begin
      side4_d.pole = POLE_NORTH;
    end else if (lhs < -rhs) begin
      side4_d.pole = POLE_SOUTH;
    end
    if (side4_d.pole != POLE_NONE) begin
      side4_d.yaw_y = AW'(y3_q);
      side4_d.yaw_x = AW'(x3_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side4_q <= side4_d;
    end
  end

  // stage 5: s squared, stage 6: radicand
  logic [SW-2:0] smag;
  logic [RW-1:0] sq_q;
  qte_side_t     side5_q;
  qte_sqrt_t     sqi_q;
  qte_sqrt_t     sqst_q [SQ_STEPS];

  assign smag = side4_q.s[SW-1] ? (SW-1)'(-side4_q.s) : (SW-1)'(side4_q.s);

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q       <= RW'(smag) * RW'(smag);
      side5_q    <= side4_q;
      sqi_q.n    <= (RW'(1) << (2 * (SQ_STEPS - 1))) - sq_q;
      sqi_q.r    <= '0;
      sqi_q.side <= side5_q;
    end
  end

  // integer square root, one result bit per stage
  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    localparam logic [RW-1:0] B = RW'(1) << (2 * (SQ_STEPS - 1 - j));
    qte_sqrt_t cur, nxt;
    logic [RW-1:0] trial;
    if (j == 0) begin : g_first
      assign cur = sqi_q;
    end else begin : g_next
      assign cur = sqst_q[j-1];
    end
    always_comb begin
      trial    = cur.r + B;
      nxt      = cur;
      if (cur.n >= trial) begin
        nxt.n = cur.n - trial;
        nxt.r = (cur.r >> 1) + B;
      end else begin
        nxt.r = cur.r >> 1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        sqst_q[j] <= nxt;
      end
    end
  end

  // atan2 units
  qte_sqrt_t sq_last;
  logic signed [ZW-1:0] zp, zy, zr;
  logic [1:0] pole_dl_q [LA];

  assign sq_last = sqst_q[SQ_STEPS-1];

  qte_atan2 #(.STEPS(CORDIC_STEPS)) u_pitch (
    .clk_i (clk_i),
    .en_i  (en),
    .y_i   (AW'(sq_last.side.s)),
    .x_i   ($signed(sq_last.r[AW-1:0])),
    .z_o   (zp)
  );

  qte_atan2 #(.STEPS(CORDIC_STEPS)) u_yaw (
    .clk_i (clk_i),
    .en_i  (en),
    .y_i   (sq_last.side.yaw_y),
    .x_i   (sq_last.side.yaw_x),
    .z_o   (zy)
  );

  qte_atan2 #(.STEPS(CORDIC_STEPS)) u_roll (
    .clk_i (clk_i),
    .en_i  (en),
    .y_i   (sq_last.side.roll_y),
    .x_i   (sq_last.side.roll_x),
    .z_o   (zr)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      pole_dl_q[0] <= sq_last.side.pole;
      for (int i = 1; i < LA; i++) begin
        pole_dl_q[i] <= pole_dl_q[i-1];
      end
    end
  end

  // output stage
  function automatic logic signed [ZW-1:0] lift_ang(input logic signed [ZW-1:0] a);
    logic signed [ZW-1:0] r;
    r = a;
    if (a < -Z_PI) begin
      r = a + Z_TWO_PI;
    end else if (a < 0) begin
      r = a + Z_PI;
    end
    return r;
  endfunction

  function automatic logic [OW-1:0] to_out(input logic signed [ZW+1:0] q);
    logic signed [ZW+1:0] t;
    t = q + (ZW+2)'(8);
    return t[OW+3:4];
  endfunction

  logic [1:0]    pole;
  logic [OW-1:0] pitch_d, yaw_d, roll_d;
  logic [OW-1:0] pitch_q, yaw_q, roll_q;
  logic [1:0]    pole_q;
  logic signed [ZW+1:0] zy2;

  assign pole = pole_dl_q[LA-1];
  assign zy2  = (ZW+2)'(zy) <<< 1;

  always_comb begin
    pitch_d = to_out((ZW+2)'(lift_ang(zp)));
    yaw_d   = to_out((ZW+2)'(lift_ang(zy)));
    roll_d  = to_out((ZW+2)'(lift_ang(zr)));
    if (pole == POLE_NORTH) begin
      pitch_d = OUT_HALF_PI;
      yaw_d   = to_out(zy2);
      roll_d  = '0;
    end else if (pole == POLE_SOUTH) begin
      pitch_d = -OUT_HALF_PI;
      yaw_d   = to_out(-zy2);
      roll_d  = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pitch_q <= pitch_d;
      yaw_q   <= yaw_d;
      roll_q  <= roll_d;
      pole_q  <= pole;
    end
  end

  assign pitch_angle_o = pitch_q;
  assign yaw_angle_o   = yaw_q;
  assign roll_angle_o  = roll_q;
  assign pole_case_o   = pole_q;

`ifndef ASSERT_OFF
  a_pole_roll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pole_case_o != POLE_NONE |-> roll_angle_o == '0)
    else $error("pole item with nonzero roll");

  a_north_pitch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pole_case_o == POLE_NORTH |-> pitch_angle_o == OUT_HALF_PI)
    else $error("north pole pitch wrong");

  a_south_pitch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pole_case_o == POLE_SOUTH |-> pitch_angle_o == -OUT_HALF_PI)
    else $error("south pole pitch wrong");

  a_regular_lifted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pole_case_o == POLE_NONE |->
      !pitch_angle_o[OW-1] && !yaw_angle_o[OW-1] && !roll_angle_o[OW-1])
    else $error("regular item with negative angle");
`endif

endmodule

`default_nettype wire

/* design/qte_atan2.sv */
// qte_atan2: pipelined vectoring CORDIC atan2 in Q16, with quadrant fold and
// power-of-two normalisation. Depends on qte_pkg.
`default_nettype none

module qte_atan2
  import qte_pkg::*;
#(
  parameter int STEPS = 14
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [AW-1:0] y_i,
  input  logic signed [AW-1:0] x_i,
  output logic signed [ZW-1:0] z_o
);

  typedef struct packed {
    logic signed [AW-1:0] x;
    logic signed [AW-1:0] y;
    logic [AW-1:0]        m;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } qte_norm_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } qte_rot_t;

  qte_norm_t prep_d, prep_q;
  qte_norm_t norm_q [NORM_STEPS];
  qte_rot_t  rot_in;
  qte_rot_t  rot_q [STEPS];
  logic [AW-1:0] yabs, xabs;

  always_comb begin
    prep_d.zero = (x_i == '0) && (y_i == '0);
    prep_d.x    = x_i;
    prep_d.y    = y_i;
    prep_d.z    = '0;
    if (x_i[AW-1]) begin
      if (!y_i[AW-1]) begin
        prep_d.x = y_i;
        prep_d.y = -x_i;
        prep_d.z = Z_HALF_PI;
      end else begin
        prep_d.x = -y_i;
        prep_d.y = x_i;
        prep_d.z = -Z_HALF_PI;
      end
    end
    xabs     = prep_d.x;
    yabs     = prep_d.y[AW-1] ? AW'(-prep_d.y) : AW'(prep_d.y);
    prep_d.m = (xabs > yabs) ? xabs : yabs;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prep_q <= prep_d;
    end
  end

  // scale so that the larger magnitude lands in [2^28, 2^29)
  for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
    localparam int K = norm_shift(j);
    qte_norm_t cur, nxt;
    if (j == 0) begin : g_first
      assign cur = prep_q;
    end else begin : g_next
      assign cur = norm_q[j-1];
    end
    always_comb begin
      nxt = cur;
      if (j < NORM_HALF) begin
        if (cur.m >= (AW'(1) << (28 + K))) begin
          nxt.m = cur.m >> K;
          nxt.x = cur.x >>> K;
          nxt.y = cur.y >>> K;
        end
      end else begin
        if (cur.m < (AW'(1) << (29 - K))) begin
          nxt.m = cur.m << K;
          nxt.x = cur.x <<< K;
          nxt.y = cur.y <<< K;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        norm_q[j] <= nxt;
      end
    end
  end

  assign rot_in.x    = CW'(norm_q[NORM_STEPS-1].x);
  assign rot_in.y    = CW'(norm_q[NORM_STEPS-1].y);
  assign rot_in.z    = norm_q[NORM_STEPS-1].z;
  assign rot_in.zero = norm_q[NORM_STEPS-1].zero;

  for (genvar i = 0; i < STEPS; i++) begin : g_rot
    localparam logic signed [ZW-1:0] ANG = atan_q16(i);
    qte_rot_t cur, nxt;
    logic signed [CW-1:0] dx, dy;
    if (i == 0) begin : g_first
      assign cur = rot_in;
    end else begin : g_next
      assign cur = rot_q[i-1];
    end
    always_comb begin
      dx       = cur.y >>> i;
      dy       = cur.x >>> i;
      nxt.zero = cur.zero;
      if (cur.y > 0) begin
        nxt.x = cur.x + dx;
        nxt.y = cur.y - dy;
        nxt.z = cur.z + ANG;
      end else begin
        nxt.x = cur.x - dx;
        nxt.y = cur.y + dy;
        nxt.z = cur.z - ANG;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rot_q[i] <= nxt;
      end
    end
  end

  assign z_o = rot_q[STEPS-1].zero ? '0 : rot_q[STEPS-1].z;

endmodule

`default_nettype wire
